// ===== hdl/gcv_pkg.sv =====
// Shared types and constants of the GLB container validator.
package gcv_pkg;

    localparam int COUNT_BITS_DEF = 32;

    localparam logic [31:0] MAGIC_GLTF   = 32'h4654_6c67;
    localparam logic [31:0] TAG_JSON     = 32'h4e4f_534a;
    localparam logic [31:0] TAG_BIN      = 32'h004e_4942;
    localparam logic [31:0] MIN_FILE     = 32'd28;
    localparam logic [31:0] JSON_HDR_END = 32'd20;
    localparam logic [31:0] MAX_FILE_RST = 32'd33554432;
    localparam logic [6:0]  MAX_NEST_RST = 7'd64;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_RBRACK = 8'h5d;

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_JSONHDR   = 3'd1,
        PH_JSONBODY  = 3'd2,
        PH_CHUNKLEN  = 3'd3,
        PH_CHUNKTYPE = 3'd4,
        PH_CHUNKBODY = 3'd5
    } t_phase;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_CONTAINER  = 4'd1,
        ST_JSON_HDR   = 4'd2,
        ST_TOO_DEEP   = 4'd3,
        ST_UNDERFLOW  = 4'd4,
        ST_JSON_OPEN  = 4'd5,
        ST_TRUNCATED  = 4'd6,
        ST_CHUNK_LEN  = 4'd7,
        ST_DUP_BIN    = 4'd8,
        ST_FOREIGN    = 4'd9,
        ST_NO_BIN     = 4'd10
    } t_status;

    typedef enum logic {
        REG_MAX_FILE = 1'b0,
        REG_MAX_NEST = 1'b1
    } t_reg_idx;

endpackage

// ===== hdl/gcv_if.sv =====
// Stream interfaces for the file bytes and for the verdict.
interface gcv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface gcv_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [31:0] total_bytes;
    logic [31:0] json_bytes;

    modport source (output valid, output status, output total_bytes, output json_bytes,
                    input ready);
    modport sink   (input valid, input status, input total_bytes, input json_bytes,
                    output ready);
endinterface

// ===== hdl/glb_container_validator.sv =====
// Top level: GLB 2.0 container validator with APB register port.
// The block takes one file byte per cycle while input ready is high and updates
// its parse state in that same cycle; the verdict for a file is registered, on the
// transfer of the byte that carries last_byte, in an output register backed by one
// skid entry, so bytes keep flowing while a verdict waits and input ready drops only
// when two verdicts are pending. Sustained rate is one byte per clock while ready is
// high, set by the per-byte update of the counter and chunk-length registers.
// Registers: max_file_bytes at 0x0, max_nesting at 0x4; write them only while no
// file is in flight.
module glb_container_validator #(
    parameter int COUNT_BITS = gcv_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gcv_in_if.sink      i_byte,
    gcv_out_if.source   o_verdict,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gcv_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [31:0]           r_max_file;
    logic [6:0]            r_max_nest;

    logic [COUNT_BITS-1:0] r_count,     n_count;
    logic [31:0]           r_word,      n_word;
    logic [31:0]           r_decl,      n_decl;
    logic [31:0]           r_json,      n_json;
    logic [31:0]           r_remain,    n_remain;
    logic [31:0]           r_chunk_len, n_chunk_len;
    t_phase                r_phase,     n_phase;
    logic [6:0]            r_depth,     n_depth;
    logic                  r_in_str,    n_in_str;
    logic                  r_esc,       n_esc;
    logic                  r_bin_seen,  n_bin_seen;
    logic                  r_cont_bad,  n_cont_bad;
    t_status               r_first_err, n_first_err;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [31:0]           r_out_total;
    logic [31:0]           r_out_json;
    logic                  r_skd_valid;
    t_status               r_skd_status;
    logic [31:0]           r_skd_total;
    logic [31:0]           r_skd_json;

    logic                  accept;
    logic                  verdict_valid;
    logic [7:0]            c;
    logic [31:0]           cnt32;
    logic                  word_done;
    logic                  fits;
    logic                  cont_fail;
    t_status               verdict;
    logic                  cfg_wr;
    t_reg_idx              reg_idx;

    assign c             = i_byte.data_byte;
    assign accept        = i_byte.valid && i_byte.ready;
    assign verdict_valid = accept && i_byte.last_byte;
    assign i_byte.ready  = !r_skd_valid;

    // parse step for one byte
    always_comb begin
        n_count     = r_count;
        n_cont_bad  = r_cont_bad;
        n_decl      = r_decl;
        n_json      = r_json;
        n_remain    = r_remain;
        n_chunk_len = r_chunk_len;
        n_phase     = r_phase;
        n_depth     = r_depth;
        n_in_str    = r_in_str;
        n_esc       = r_esc;
        n_bin_seen  = r_bin_seen;
        n_first_err = r_first_err;
        fits        = 1'b0;

        if (r_count == CNT_MAX) begin
            n_cont_bad = 1'b1;
        end else begin
            n_count = r_count + 1'b1;
        end
        cnt32     = 32'(n_count);
        n_word    = {c, r_word[31:8]};
        word_done = (r_count[1:0] == 2'b11);

        unique case (r_phase)
            PH_HEADER: begin
                if (r_count == COUNT_BITS'(3) && n_word != MAGIC_GLTF) begin
                    n_cont_bad = 1'b1;
                end
                if (r_count == COUNT_BITS'(7) && n_word != 32'd2) begin
                    n_cont_bad = 1'b1;
                end
                if (r_count == COUNT_BITS'(11)) begin
                    n_decl  = n_word;
                    n_phase = PH_JSONHDR;
                end
            end
            PH_JSONHDR: begin
                if (r_count == COUNT_BITS'(15)) begin
                    n_json = n_word;
                end
                if (r_count == COUNT_BITS'(19)) begin
                    fits = (r_decl >= JSON_HDR_END) && (r_json <= r_decl - JSON_HDR_END);
                    if (n_word != TAG_JSON || r_json[1:0] != 2'b00 || !fits) begin
                        if (n_first_err == ST_OK) n_first_err = ST_JSON_HDR;
                    end
                    n_remain = r_json;
                    n_phase  = (r_json == '0) ? PH_CHUNKLEN : PH_JSONBODY;
                end
            end
            PH_JSONBODY: begin
                if (r_in_str) begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                    end else if (c == CH_BSLASH) begin
                        n_esc = 1'b1;
                    end else if (c == CH_QUOTE) begin
                        n_in_str = 1'b0;
                    end
                end else begin
                    case (c) inside
                        CH_QUOTE: begin
                            n_in_str = 1'b1;
                        end
                        CH_LBRACE, CH_LBRACK: begin
                            if (r_depth >= r_max_nest) begin
                                if (n_first_err == ST_OK) n_first_err = ST_TOO_DEEP;
                            end else begin
                                n_depth = r_depth + 1'b1;
                            end
                        end
                        CH_RBRACE, CH_RBRACK: begin
                            if (r_depth == '0) begin
                                if (n_first_err == ST_OK) n_first_err = ST_UNDERFLOW;
                            end else begin
                                n_depth = r_depth - 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                n_remain = r_remain - 1'b1;
                if (n_remain == '0) begin
                    if (n_depth != '0 || n_in_str) begin
                        if (n_first_err == ST_OK) n_first_err = ST_JSON_OPEN;
                    end
                    n_phase = PH_CHUNKLEN;
                end
            end
            PH_CHUNKLEN: begin
                if (word_done) begin
                    n_chunk_len = n_word;
                    n_phase     = PH_CHUNKTYPE;
                end
            end
            PH_CHUNKTYPE: begin
                if (word_done) begin
                    fits = (r_decl >= cnt32) && (r_chunk_len <= r_decl - cnt32);
                    if (r_chunk_len[1:0] != 2'b00 || !fits) begin
                        if (n_first_err == ST_OK) n_first_err = ST_CHUNK_LEN;
                    end else if (n_word != TAG_BIN) begin
                        if (n_first_err == ST_OK) n_first_err = ST_FOREIGN;
                    end else if (r_bin_seen) begin
                        if (n_first_err == ST_OK) n_first_err = ST_DUP_BIN;
                    end else begin
                        n_bin_seen = 1'b1;
                    end
                    n_remain = r_chunk_len;
                    n_phase  = (r_chunk_len == '0) ? PH_CHUNKLEN : PH_CHUNKBODY;
                end
            end
            default: begin
                if (r_remain != '0) begin
                    n_remain = r_remain - 1'b1;
                end
                if (n_remain == '0) begin
                    n_phase = PH_CHUNKLEN;
                end
            end
        endcase

        // end-of-file checks
        verdict = n_first_err;
        if (r_phase == PH_CHUNKLEN || (r_phase == PH_CHUNKTYPE && n_phase == PH_CHUNKTYPE)) begin
            if (verdict == ST_OK) verdict = ST_TRUNCATED;
        end
        if (!n_bin_seen) begin
            if (verdict == ST_OK) verdict = ST_NO_BIN;
        end
        cont_fail = n_cont_bad || (cnt32 < MIN_FILE) || (cnt32 > r_max_file)
                    || (n_decl != cnt32);
        if (cont_fail) begin
            verdict = ST_CONTAINER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || verdict_valid) begin
            r_count     <= '0;
            r_word      <= '0;
            r_decl      <= '0;
            r_json      <= '0;
            r_remain    <= '0;
            r_chunk_len <= '0;
            r_phase     <= PH_HEADER;
            r_depth     <= '0;
            r_in_str    <= 1'b0;
            r_esc       <= 1'b0;
            r_bin_seen  <= 1'b0;
            r_cont_bad  <= 1'b0;
            r_first_err <= ST_OK;
        end else if (accept) begin
            r_count     <= n_count;
            r_word      <= n_word;
            r_decl      <= n_decl;
            r_json      <= n_json;
            r_remain    <= n_remain;
            r_chunk_len <= n_chunk_len;
            r_phase     <= n_phase;
            r_depth     <= n_depth;
            r_in_str    <= n_in_str;
            r_esc       <= n_esc;
            r_bin_seen  <= n_bin_seen;
            r_cont_bad  <= n_cont_bad;
            r_first_err <= n_first_err;
        end
    end

    // verdict output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (!r_out_valid || o_verdict.ready) begin
            if (r_skd_valid) begin
                r_out_valid <= 1'b1;
                r_skd_valid <= 1'b0;
            end else begin
                r_out_valid <= verdict_valid;
            end
        end else if (verdict_valid) begin
            r_skd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_verdict.ready) begin
            if (r_skd_valid) begin
                r_out_status <= r_skd_status;
                r_out_total  <= r_skd_total;
                r_out_json   <= r_skd_json;
            end else if (verdict_valid) begin
                r_out_status <= verdict;
                r_out_total  <= cnt32;
                r_out_json   <= n_json;
            end
        end else if (verdict_valid) begin
            r_skd_status <= verdict;
            r_skd_total  <= cnt32;
            r_skd_json   <= n_json;
        end
    end

    assign o_verdict.valid       = r_out_valid;
    assign o_verdict.status      = r_out_status;
    assign o_verdict.total_bytes = r_out_total;
    assign o_verdict.json_bytes  = r_out_json;

    // register port
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_file <= MAX_FILE_RST;
            r_max_nest <= MAX_NEST_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_MAX_FILE: r_max_file <= pwdata;
                REG_MAX_NEST: r_max_nest <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MAX_FILE: prdata = r_max_file;
            REG_MAX_NEST: prdata = {25'b0, r_max_nest};
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== hdl/gcv_checker.sv =====
// Port-level assertions for the GLB container validator, bound to the top level.
module gcv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  out_status,
    input logic [31:0] out_total,
    input logic [31:0] out_json
);
    import gcv_pkg::*;

    a_no_verdict_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("verdict shown right after reset");

    a_verdict_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status)
            && $stable(out_total) && $stable(out_json))
        else $error("stalled verdict changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_status <= ST_NO_BIN)
        else $error("status code out of range");

    a_ok_min_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_status == ST_OK |-> out_total >= MIN_FILE)
        else $error("ok verdict for a file below minimum size");

    a_counts_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_total != 32'd0)
        else $error("verdict with zero byte count");

endmodule

bind glb_container_validator gcv_checker u_gcv_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .out_valid  (o_verdict.valid),
    .out_ready  (o_verdict.ready),
    .out_status (o_verdict.status),
    .out_total  (o_verdict.total_bytes),
    .out_json   (o_verdict.json_bytes)
);
